### sv/tsa_pkg.sv
// Shared types, constants, microcode program and reciprocal table for the sine block.
package tsa_pkg;

    // Field and datapath widths
    localparam int ANGLE_W = 32;
    localparam int SINE_W  = 48;
    localparam int TC_W    = 4;
    localparam int XMAG_W  = 32;
    localparam int X2_W    = 35;
    localparam int TERM_W  = 47;
    localparam int RCP_W   = 30;
    localparam int HALF_W  = 24;
    localparam int PROD_W  = HALF_W + X2_W;
    localparam int ACC_W   = TERM_W + X2_W + 3;
    localparam int STEP_W  = 4;

    // Series length
    localparam int MAX_TERMS = 10;
    localparam logic [TC_W-1:0] TC_RESET = TC_W'(5);
    localparam logic [TC_W-1:0] TC_MAX   = TC_W'(MAX_TERMS);
    localparam logic [TC_W-1:0] TC_MIN   = TC_W'(1);

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_TERM_COUNT = 1'b0;

    // Rounding and clamp constants
    localparam logic [ACC_W-1:0]  RND_Q28  = ACC_W'(1) << 27;
    localparam logic [ACC_W-1:0]  RND_Q32  = ACC_W'(1) << 31;
    localparam logic [TERM_W-1:0] TERM_LIM = {TERM_W{1'b1}};
    localparam logic signed [SINE_W-1:0] SUM_MAX = {1'b0, {(SINE_W-1){1'b1}}};
    localparam logic signed [SINE_W-1:0] SUM_MIN = {1'b1, {(SINE_W-1){1'b0}}};

    typedef enum logic [0:0] { A_XMAG, A_TMAG } a_sel_t;
    typedef enum logic [1:0] { B_XMAG, B_X2, B_RECIP } b_sel_t;
    typedef enum logic [1:0] { MUL_NONE, MUL_LO, MUL_HI } mul_op_t;
    typedef enum logic [1:0] { DEST_NONE, DEST_X2, DEST_TMAG } dest_t;
    typedef enum logic [1:0] { JMP_NEXT, JMP_ALWAYS, JMP_IF_LAST } jmp_t;

    // One microcode word
    typedef struct packed {
        a_sel_t              a_sel;
        b_sel_t              b_sel;
        mul_op_t             mul_op;
        logic                shift32;
        dest_t               dest;
        logic                flag_sat;
        logic                flip_sign;
        logic                add_term;
        logic                wait_in;
        logic                wait_out;
        jmp_t                jmp;
        logic [STEP_W-1:0]   target;
    } ctrl_t;

    typedef struct packed {
        logic last;
    } status_t;

    // Program addresses
    localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SQ_LO  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SQ_HI  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SQ_RND = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ADD    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_MX_HI  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_MX_RND = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MR_LO  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_MR_HI  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_MR_RND = 4'd9;
    localparam logic [STEP_W-1:0] STEP_DONE   = 4'd10;

    // Microcode ROM
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = '0;
        case (step)
            STEP_WAIT:
            begin
                cw.wait_in = 1'b1;
            end
            STEP_SQ_LO:
            begin
                cw.a_sel  = A_XMAG;
                cw.b_sel  = B_XMAG;
                cw.mul_op = MUL_LO;
            end
            STEP_SQ_HI:
            begin
                cw.a_sel  = A_XMAG;
                cw.b_sel  = B_XMAG;
                cw.mul_op = MUL_HI;
            end
            STEP_SQ_RND:
            begin
                cw.dest = DEST_X2;
            end
            STEP_ADD:
            begin
                cw.add_term = 1'b1;
                cw.a_sel    = A_TMAG;
                cw.b_sel    = B_X2;
                cw.mul_op   = MUL_LO;
                cw.jmp      = JMP_IF_LAST;
                cw.target   = STEP_DONE;
            end
            STEP_MX_HI:
            begin
                cw.a_sel  = A_TMAG;
                cw.b_sel  = B_X2;
                cw.mul_op = MUL_HI;
            end
            STEP_MX_RND:
            begin
                cw.dest     = DEST_TMAG;
                cw.flag_sat = 1'b1;
            end
            STEP_MR_LO:
            begin
                cw.a_sel   = A_TMAG;
                cw.b_sel   = B_RECIP;
                cw.mul_op  = MUL_LO;
                cw.shift32 = 1'b1;
            end
            STEP_MR_HI:
            begin
                cw.a_sel   = A_TMAG;
                cw.b_sel   = B_RECIP;
                cw.mul_op  = MUL_HI;
                cw.shift32 = 1'b1;
            end
            STEP_MR_RND:
            begin
                cw.dest      = DEST_TMAG;
                cw.shift32   = 1'b1;
                cw.flag_sat  = 1'b1;
                cw.flip_sign = 1'b1;
                cw.jmp       = JMP_ALWAYS;
                cw.target    = STEP_ADD;
            end
            STEP_DONE:
            begin
                cw.wait_out = 1'b1;
                cw.jmp      = JMP_ALWAYS;
                cw.target   = STEP_WAIT;
            end
            default:
            begin
                cw.jmp    = JMP_ALWAYS;
                cw.target = STEP_WAIT;
            end
        endcase
        return cw;
    endfunction

    // round(2^32 / ((2i)(2i+1))) for i = k+1
    function automatic logic [RCP_W-1:0] recip(input logic [TC_W-1:0] k);
        logic [RCP_W-1:0] r;
        case (k)
            4'd0:    r = 30'd715827883;
            4'd1:    r = 30'd214748365;
            4'd2:    r = 30'd102261126;
            4'd3:    r = 30'd59652324;
            4'd4:    r = 30'd39045157;
            4'd5:    r = 30'd27531842;
            4'd6:    r = 30'd20452225;
            4'd7:    r = 30'd15790321;
            4'd8:    r = 30'd12558384;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

### sv/tsa_sequencer.sv
// Step counter and microcode fetch for the sine block.
module tsa_sequencer
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            out_free,
    input  tsa_pkg::status_t status,
    output tsa_pkg::ctrl_t  cw,
    output logic            in_ready,
    output logic            out_load
);
    import tsa_pkg::*;

    logic [STEP_W-1:0] pc_reg;
    logic [STEP_W-1:0] pc_next;
    logic              hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    always_comb
    begin
        cw       = ucode(pc_reg);
        in_ready = cw.wait_in;
        out_load = cw.wait_out && out_free;
        hold     = (cw.wait_in && !in_valid) || (cw.wait_out && !out_free);
        pc_next  = pc_reg;
        if (!hold)
        begin
            case (cw.jmp)
                JMP_NEXT:    pc_next = pc_reg + STEP_W'(1);
                JMP_ALWAYS:  pc_next = cw.target;
                JMP_IF_LAST: pc_next = status.last ? cw.target : pc_reg + STEP_W'(1);
                default:     pc_next = STEP_WAIT;
            endcase
        end
    end

endmodule

### sv/tsa_datapath.sv
// Shared multiplier, rounding clamp, term and sum registers of the sine block.
module tsa_datapath
(
    input  logic                                 clk,
    input  tsa_pkg::ctrl_t                       cw,
    input  logic                                 in_fire,
    input  logic signed [tsa_pkg::ANGLE_W-1:0]   angle,
    input  logic [tsa_pkg::TC_W-1:0]             term_count,
    output tsa_pkg::status_t                     status,
    output logic signed [tsa_pkg::SINE_W-1:0]    sum,
    output logic                                 sat
);
    import tsa_pkg::*;

    logic [XMAG_W-1:0]         xmag_reg;
    logic [X2_W-1:0]           x2_reg;
    logic [TERM_W-1:0]         tmag_reg;
    logic                      tneg_reg;
    logic signed [SINE_W-1:0]  sum_reg;
    logic                      sat_reg;
    logic [TC_W-1:0]           cnt_reg;
    logic [ACC_W-1:0]          acc_reg;

    logic [TERM_W-1:0]         a_op;
    logic [X2_W-1:0]           b_op;
    logic [HALF_W-1:0]         half;
    logic [PROD_W-1:0]         prod;
    logic [ACC_W-1:0]          acc_next;
    logic [ACC_W-1:0]          shifted;
    logic                      ovf;
    logic [TERM_W-1:0]         rnd_val;
    logic signed [SINE_W:0]    sum_raw;
    logic signed [SINE_W-1:0]  sum_next;
    logic [TC_W-1:0]           n_eff;

    // Clamp the term count into the supported range
    always_comb
    begin
        if (term_count < TC_MIN)
        begin
            n_eff = TC_MIN;
        end
        else if (term_count > TC_MAX)
        begin
            n_eff = TC_MAX;
        end
        else
        begin
            n_eff = term_count;
        end
        status.last = (cnt_reg + TC_W'(1)) == n_eff;
    end

    // Two passes per product: low half of a plus rounding bias, then high half
    always_comb
    begin
        a_op = (cw.a_sel == A_TMAG) ? tmag_reg : TERM_W'(xmag_reg);
        case (cw.b_sel)
            B_XMAG:  b_op = X2_W'(xmag_reg);
            B_X2:    b_op = x2_reg;
            B_RECIP: b_op = X2_W'(recip(cnt_reg - TC_W'(1)));
            default: b_op = '0;
        endcase
        half = (cw.mul_op == MUL_HI) ? HALF_W'(a_op[TERM_W-1:HALF_W]) : a_op[HALF_W-1:0];
        prod = PROD_W'(half) * PROD_W'(b_op);
        case (cw.mul_op)
            MUL_LO:  acc_next = ACC_W'(prod) + (cw.shift32 ? RND_Q32 : RND_Q28);
            MUL_HI:  acc_next = acc_reg + (ACC_W'(prod) << HALF_W);
            default: acc_next = acc_reg;
        endcase
    end

    // Drop the fraction and clamp the magnitude
    always_comb
    begin
        shifted = cw.shift32 ? (acc_reg >> 32) : (acc_reg >> 28);
        ovf     = |shifted[ACC_W-1:TERM_W];
        rnd_val = ovf ? TERM_LIM : shifted[TERM_W-1:0];
    end

    // Signed accumulate with saturation
    always_comb
    begin
        if (tneg_reg)
        begin
            sum_raw = {sum_reg[SINE_W-1], sum_reg} - signed'({2'b00, tmag_reg});
        end
        else
        begin
            sum_raw = {sum_reg[SINE_W-1], sum_reg} + signed'({2'b00, tmag_reg});
        end
        case (sum_raw[SINE_W:SINE_W-1])
            2'b01:   sum_next = SUM_MAX;
            2'b10:   sum_next = SUM_MIN;
            default: sum_next = sum_raw[SINE_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_fire)
        begin
            xmag_reg <= angle[ANGLE_W-1] ? XMAG_W'(-angle) : XMAG_W'(angle);
            // zero-extend the magnitude: the most negative angle has bit 31 set
            tmag_reg <= angle[ANGLE_W-1] ? TERM_W'(unsigned'(XMAG_W'(-angle)))
                                         : TERM_W'(unsigned'(XMAG_W'(angle)));
            tneg_reg <= angle[ANGLE_W-1];
            sum_reg  <= '0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cw.dest == DEST_X2)
            begin
                x2_reg <= rnd_val[X2_W-1:0];
            end
            if (cw.dest == DEST_TMAG)
            begin
                tmag_reg <= rnd_val;
            end
            if (cw.flip_sign)
            begin
                tneg_reg <= ~tneg_reg;
            end
            if (cw.add_term)
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_reg + TC_W'(1);
            end
            if ((cw.flag_sat && ovf) ||
                (cw.add_term && (sum_raw[SINE_W] != sum_raw[SINE_W-1])))
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    assign sum = sum_reg;
    assign sat = sat_reg;

endmodule

### sv/taylor_sine_approx.sv
// Top level of the microcoded Taylor series sine block with its register port.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_ready   angle (Q3.28, signed)
//   result    out        out_valid / out_ready sine_value (Q19.28, signed), saturated
//   config    in/out     psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// An item runs through these steps from one accepted transfer to the earliest
// next one: one to take the angle, three for x squared, six for each further
// term up to the clamped term count (the add shares its cycle with the
// low pass of the product by x squared, then the high pass and a clamp step,
// then the same three for the reciprocal), the last add and the hand-off
// step, all through the single 24x35 multiplier. Reset clears the step
// counter, the result valid flag and sets term_count to 5. A stalled result
// is held in the output register while the next angle is taken; only the
// final hand-off step waits for the output register to drain.
module taylor_sine_approx
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [tsa_pkg::ANGLE_W-1:0]  angle,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [tsa_pkg::SINE_W-1:0]   sine_value,
    output logic                                saturated,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [tsa_pkg::PADDR_W-1:0]         paddr,
    input  logic [tsa_pkg::PDATA_W-1:0]         pwdata,
    output logic [tsa_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);
    import tsa_pkg::*;

    logic [TC_W-1:0]           term_count_reg;
    logic                      out_valid_reg;
    logic signed [SINE_W-1:0]  sine_value_reg;
    logic                      saturated_reg;

    ctrl_t                     cw;
    status_t                   status;
    logic                      in_fire;
    logic                      out_free;
    logic                      out_load;
    logic signed [SINE_W-1:0]  sum;
    logic                      sat;
    logic                      cfg_wr;

    // Register port: one register, pready always high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_TERM_COUNT) ? PDATA_W'(term_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TC_RESET;
        end
        else if (cfg_wr && (paddr[2] == REG_TERM_COUNT))
        begin
            term_count_reg <= pwdata[TC_W-1:0];
        end
    end

    // Output register frees up when empty or when its transfer completes
    assign out_free = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    tsa_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .status   (status),
        .cw       (cw),
        .in_ready (in_ready),
        .out_load (out_load)
    );

    tsa_datapath u_dp
    (
        .clk        (clk),
        .cw         (cw),
        .in_fire    (in_fire),
        .angle      (angle),
        .term_count (term_count_reg),
        .status     (status),
        .sum        (sum),
        .sat        (sat)
    );

    // Hold the result until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sine_value_reg <= sum;
            saturated_reg  <= sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sine_value = sine_value_reg;
    assign saturated  = saturated_reg;

endmodule
